@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`endif

@@ rtl/core/pop3cap_pkg.sv @@
// shared types and constants of the pop3 credential capture block
`timescale 1ns / 1ps
`default_nettype none

package pop3cap_pkg;

  localparam int FieldBytes = 24;
  localparam int LenW       = $clog2(FieldBytes + 1);
  // name entries in the lower half, password entries in the upper half
  localparam int AddrW      = LenW + 1;

  typedef enum logic [2:0] {
    PhGreet   = 3'd0,
    PhUserCmd = 3'd1,
    PhName    = 3'd2,
    PhPassCmd = 3'd3,
    PhSecret  = 3'd4,
    PhReply   = 3'd5,
    PhOk      = 3'd6,
    PhError   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindStatus = 2'd0,
    KindName   = 2'd1,
    KindSecret = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    phase_e      phase;
    logic        last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/core/pop3cap_ram.sv @@
// single-port synchronous ram, registered read data
`timescale 1ns / 1ps
`default_nettype none

module pop3cap_ram #(
  parameter int Width = 8,
  parameter int AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  localparam int Depth = 1 << AddrW;

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pop3cap_ctrl.sv @@
// session parser and success-burst sequencer around the capture store
`timescale 1ns / 1ps
`default_nettype none

module pop3cap_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            byte_in_i,
  input  wire logic                  chunk_start_i,
  input  wire logic                  res_ready_i,
  output logic                       res_valid_o,
  output pop3cap_pkg::res_t          res_o,
  output pop3cap_pkg::mem_req_t      mem_o,
  input  wire logic [7:0]            mem_rdata_i
);

  localparam int LenW = pop3cap_pkg::LenW;
  localparam logic [LenW-1:0] FieldMax = LenW'(pop3cap_pkg::FieldBytes);

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChU     = 8'h55;

  typedef enum logic [1:0] {
    StRun,
    StRead,
    StSend
  } state_e;

  function automatic logic [7:0] upcase(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic hit_ok(logic [2:0] pos, logic [7:0] c);
    logic [7:0] u;
    u = upcase(c);
    case (pos)
      3'd0:    return u == ChPlus;
      3'd1:    return u == ChO;
      3'd2:    return u == ChK;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic hit_err(logic [2:0] pos, logic [7:0] c);
    logic [7:0] u;
    u = upcase(c);
    case (pos)
      3'd0:    return u == ChMinus;
      3'd1:    return u == ChE;
      3'd2:    return u == ChR;
      3'd3:    return u == ChR;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic hit_user(logic [2:0] pos, logic [7:0] c);
    logic [7:0] u;
    u = upcase(c);
    case (pos)
      3'd0:    return u == ChU;
      3'd1:    return u == ChS;
      3'd2:    return u == ChE;
      3'd3:    return u == ChR;
      3'd4:    return u == ChSpace;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic hit_pass(logic [2:0] pos, logic [7:0] c);
    logic [7:0] u;
    u = upcase(c);
    case (pos)
      3'd0:    return u == ChP;
      3'd1:    return u == ChA;
      3'd2:    return u == ChS;
      3'd3:    return u == ChS;
      3'd4:    return u == ChSpace;
      default: return 1'b0;
    endcase
  endfunction

  state_e                st_q, st_d;
  pop3cap_pkg::phase_e   phase_q, phase_d;
  logic [2:0]            match_q, match_d;
  logic [2:0]            err_q, err_d;
  logic [LenW-1:0]       name_len_q, name_len_d;
  logic [LenW-1:0]       secret_len_q, secret_len_d;
  logic [LenW-1:0]       ptr_q, ptr_d;
  logic                  sel_q, sel_d;

  // parser outcome for the byte on the input
  pop3cap_pkg::phase_e   p_phase;
  logic [2:0]            p_match;
  logic [2:0]            p_err;
  logic [LenW-1:0]       p_nl;
  logic [LenW-1:0]       p_sl;
  logic                  p_burst;
  logic                  p_we;
  logic                  p_wsel;
  logic [LenW-1:0]       p_widx;
  logic                  acc;

  assign in_stall_o = (st_q != StRun) || !res_ready_i;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    p_phase = phase_q;
    p_match = match_q;
    p_err   = err_q;
    p_nl    = name_len_q;
    p_sl    = secret_len_q;
    p_burst = 1'b0;
    p_we    = 1'b0;
    p_wsel  = 1'b0;
    p_widx  = name_len_q;

    if (chunk_start_i && (phase_q == pop3cap_pkg::PhGreet ||
                          phase_q == pop3cap_pkg::PhOk ||
                          phase_q == pop3cap_pkg::PhError)) begin
      p_phase = pop3cap_pkg::PhGreet;
      p_match = '0;
      p_err   = '0;
      p_nl    = '0;
      p_sl    = '0;
    end

    unique case (p_phase)
      pop3cap_pkg::PhGreet: begin
        if (hit_ok(p_match, byte_in_i)) begin
          if (p_match == 3'd2) begin
            p_phase = pop3cap_pkg::PhUserCmd;
            p_match = '0;
          end else begin
            p_match = p_match + 3'd1;
          end
        end else begin
          p_phase = pop3cap_pkg::PhError;
        end
      end
      pop3cap_pkg::PhUserCmd: begin
        if (hit_user(p_match, byte_in_i)) begin
          if (p_match == 3'd4) begin
            p_phase = pop3cap_pkg::PhName;
            p_match = '0;
            p_nl    = '0;
          end else begin
            p_match = p_match + 3'd1;
          end
        end else begin
          p_match = '0;
        end
      end
      pop3cap_pkg::PhName: begin
        if (byte_in_i != ChLf) begin
          if (p_nl < FieldMax) begin
            p_we   = 1'b1;
            p_wsel = 1'b0;
            p_widx = p_nl;
            p_nl   = p_nl + 1'b1;
          end
        end else begin
          p_phase = pop3cap_pkg::PhPassCmd;
          p_match = '0;
          p_err   = '0;
        end
      end
      pop3cap_pkg::PhPassCmd: begin
        if (hit_pass(p_match, byte_in_i)) begin
          if (p_match == 3'd4) begin
            p_phase = pop3cap_pkg::PhSecret;
            p_match = '0;
            p_sl    = '0;
          end else begin
            p_match = p_match + 3'd1;
          end
        end else begin
          p_match = '0;
        end
      end
      pop3cap_pkg::PhSecret: begin
        if (byte_in_i != ChLf) begin
          if (p_sl < FieldMax) begin
            p_we   = 1'b1;
            p_wsel = 1'b1;
            p_widx = p_sl;
            p_sl   = p_sl + 1'b1;
          end
        end else begin
          p_phase = pop3cap_pkg::PhReply;
          p_match = '0;
          p_err   = '0;
        end
      end
      pop3cap_pkg::PhReply: begin
        if (hit_ok(p_match, byte_in_i)) begin
          p_match = p_match + 3'd1;
          if (p_match == 3'd3) begin
            p_phase = pop3cap_pkg::PhOk;
            p_burst = 1'b1;
          end
        end else if (hit_err(p_err, byte_in_i)) begin
          if (p_err == 3'd3) begin
            p_phase = pop3cap_pkg::PhUserCmd;
            p_match = '0;
            p_err   = '0;
          end else begin
            p_err = p_err + 3'd1;
          end
        end
      end
      pop3cap_pkg::PhOk,
      pop3cap_pkg::PhError: begin
      end
    endcase
  end

  always_comb begin
    st_d         = st_q;
    phase_d      = phase_q;
    match_d      = match_q;
    err_d        = err_q;
    name_len_d   = name_len_q;
    secret_len_d = secret_len_q;
    ptr_d        = ptr_q;
    sel_d        = sel_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: pop3cap_pkg::KindStatus, ch: 8'h00, phase: p_phase, last: 1'b1};
    mem_o        = '{we: 1'b0, re: 1'b0, addr: {p_wsel, p_widx}, wdata: byte_in_i};

    unique case (st_q)
      StRun: begin
        if (acc) begin
          phase_d      = p_phase;
          match_d      = p_match;
          err_d        = p_err;
          name_len_d   = p_nl;
          secret_len_d = p_sl;
          mem_o.we     = p_we;
          if (p_burst) begin
            st_d  = StRead;
            sel_d = 1'b0;
            ptr_d = '0;
          end else begin
            res_valid_o = 1'b1;
          end
        end
      end
      StRead: begin
        if (!sel_q && ptr_q < name_len_q) begin
          mem_o.re   = 1'b1;
          mem_o.addr = {1'b0, ptr_q};
          st_d       = StSend;
        end else if (!sel_q) begin
          // name done, move on to the password entries
          sel_d = 1'b1;
          ptr_d = '0;
        end else if (ptr_q < secret_len_q) begin
          mem_o.re   = 1'b1;
          mem_o.addr = {1'b1, ptr_q};
          st_d       = StSend;
        end else if (res_ready_i) begin
          res_valid_o = 1'b1;
          res_o       = '{kind: pop3cap_pkg::KindStatus, ch: 8'h00,
                          phase: pop3cap_pkg::PhOk, last: 1'b1};
          st_d        = StRun;
        end
      end
      StSend: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          res_o       = '{kind: sel_q ? pop3cap_pkg::KindSecret : pop3cap_pkg::KindName,
                          ch: mem_rdata_i, phase: pop3cap_pkg::PhOk, last: 1'b0};
          ptr_d       = ptr_q + 1'b1;
          st_d        = StRead;
        end
      end
      default: begin
        st_d = StRun;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= StRun;
      phase_q      <= pop3cap_pkg::PhGreet;
      match_q      <= '0;
      err_q        <= '0;
      name_len_q   <= '0;
      secret_len_q <= '0;
      ptr_q        <= '0;
      sel_q        <= 1'b0;
    end else begin
      st_q         <= st_d;
      phase_q      <= phase_d;
      match_q      <= match_d;
      err_q        <= err_d;
      name_len_q   <= name_len_d;
      secret_len_q <= secret_len_d;
      ptr_q        <= ptr_d;
      sel_q        <= sel_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pop3_login_credential_capture_core.sv @@
// top level of the pop3 login credential capture block
// usage:
//   input channel: one session byte per transfer (byte_in_i, chunk_start_i) on
//   in_valid_i / in_stall_o; output channel: one result per transfer (kind_o,
//   char_out_o, phase_o, last_o) on out_valid_o / out_stall_i
//   an ordinary byte gives one status result, visible on the output register
//   in the cycle after its transfer; one byte per cycle is taken while the
//   output drains
//   a byte that completes the "+OK" reply starts a success burst: each stored
//   name and password byte is read from the capture ram and then loaded into
//   the output register, with a step to switch from name to password and a
//   closing status at the end, all while the input is held off
//   receiver stall holds the output register; once it is full and stalled the
//   input is stalled as well, nothing is dropped
//   reset clears phase, match positions and lengths and empties the output
//   register; the capture ram is not cleared (entries are only read after
//   being written), so there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module pop3_login_credential_capture_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_in_i,
  input  wire logic       chunk_start_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      char_out_o,
  output logic [2:0]      phase_o,
  output logic            last_o
);

  pop3cap_pkg::res_t     res;
  pop3cap_pkg::res_t     out_q;
  pop3cap_pkg::mem_req_t mem_req;
  logic                  res_valid;
  logic                  res_ready;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            mem_rdata;

  // output register can take a result when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  pop3cap_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .chunk_start_i (chunk_start_i),
    .res_ready_i   (res_ready),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_o         (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  // name store in the lower half, password store in the upper half
  pop3cap_ram #(
    .Width (8),
    .AddrW (pop3cap_pkg::AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload holds while stalled, loads only on a new result
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign char_out_o  = out_q.ch;
  assign phase_o     = out_q.phase;
  assign last_o      = out_q.last;

endmodule

`default_nettype wire

@@ rtl/core/pop3cap_checker.sv @@
// port-level checker for the pop3 credential capture block, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pop3cap_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] byte_in_i,
  input wire logic       chunk_start_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] kind_o,
  input wire logic [7:0] char_out_o,
  input wire logic [2:0] phase_o,
  input wire logic       last_o
);

  logic is_status;
  logic in_xfer;

  assign is_status = kind_o == pop3cap_pkg::KindStatus;
  assign in_xfer   = in_valid_i && !in_stall_o && (byte_in_i == byte_in_i)
                     && (chunk_start_i == chunk_start_i);

  // captured bytes only come in a success burst and never close it
  `ASSERT_PROP(a_burst_shape, clk_i, rst_ni, (out_valid_o && !is_status) |-> (!last_o && phase_o == pop3cap_pkg::PhOk), "captured byte outside a success burst")

  // every status closes the results of its byte and carries no character
  `ASSERT_PROP(a_status_form, clk_i, rst_ni, (out_valid_o && is_status) |-> (last_o && char_out_o == 8'h00), "malformed status result")

  // no input is taken while a captured byte waits on the output
  `ASSERT_PROP(a_burst_cont, clk_i, rst_ni, (out_valid_o && !is_status) |-> !in_xfer, "input taken in the middle of a burst")

  // a stalled result holds
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(kind_o) && $stable(char_out_o) && $stable(phase_o) && $stable(last_o)), "stalled result changed")

endmodule

bind pop3_login_credential_capture_core pop3cap_checker u_pop3cap_checker (.*);

`default_nettype wire
